### design/midpoint_ellipse_generator_unit_defines.svh
// assertion macros for the ellipse generator controller
`ifndef MIDPOINT_ELLIPSE_GENERATOR_UNIT_DEFINES_SVH
`define MIDPOINT_ELLIPSE_GENERATOR_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define MEG_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define MEG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/meg_pkg.sv
package meg_pkg;

  // accumulator width of all decision and progress terms
  localparam int unsigned ACC_W          = 40;
  localparam int unsigned AXIS_BITS_DEF  = 10;
  localparam int unsigned COORD_BITS_DEF = 12;

  // request kind carried in tuser
  localparam logic REQ_START = 1'b0;

  // operand pairs of the shared multiplier
  typedef enum logic [1:0] {
    MUL_AA  = 2'd0,
    MUL_BB  = 2'd1,
    MUL_A2B = 2'd2,
    MUL_B2A = 2'd3
  } mul_sel_e;

  // quadrant of a symmetric point, in output order
  typedef enum logic [1:0] {
    Q_PP = 2'd0,
    Q_PM = 2'd1,
    Q_MM = 2'd2,
    Q_MP = 2'd3
  } quad_e;

  typedef struct packed {
    logic     load_in;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     init_r1;
    logic     setup_r2;
    logic     upd_r1;
    logic     upd_r2;
    logic     emit_pt;
    quad_e    quad;
    logic     emit_done;
  } meg_cmd_t;

  typedef struct packed {
    logic out_free;
    logic p0_lt_p1;
    logic p1_lt_p0;
    logic p_eq;
  } meg_stat_t;

endpackage

### design/midpoint_ellipse_generator_unit.sv
// Axis-aligned midpoint ellipse rasterizer. A start word (tuser = 0) loads the centre and
// the semi-axes; once accepted, it forms four products a*a, b*b, a*a*b, b*b*a through one
// shared multiplier, then does the region setup, and gives no result. A step word
// (tuser = 1) gives the next four symmetric points (+x+y, +x-y, -x-y, -x+y), one result
// word per cycle while the output is free, with tlast on the fourth; once accepted, a
// decision step precedes the four points and repeats for each loop end and for each tail
// that gives no points. After the ellipse ends, a step gives one word with done_res set,
// no point and tlast. The input is taken only between words; results wait in a one-word
// output register while the next word is accepted.
module midpoint_ellipse_generator_unit #(
  parameter int unsigned AXIS_BITS  = meg_pkg::AXIS_BITS_DEF,
  parameter int unsigned COORD_BITS = meg_pkg::COORD_BITS_DEF,
  localparam int unsigned IN_W  = ((2 * COORD_BITS + 2 * AXIS_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((2 * (COORD_BITS + 1) + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [IN_W-1:0]  s_axis_tdata_i,   // center_x, center_y, semi_a, semi_b
  input  logic             s_axis_tuser_i,   // req_type
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [OUT_W-1:0] m_axis_tdata_o,   // point_x, point_y
  output logic [1:0]       m_axis_tuser_o,   // point_valid, done_res
  output logic             m_axis_tlast_o
);

  meg_pkg::meg_cmd_t  cmd;
  meg_pkg::meg_stat_t stat;

  // sequencer
  meg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tuser_i  (s_axis_tuser_i),
    .s_tready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // products, accumulators and output register
  meg_datapath #(
    .AXIS_BITS  (AXIS_BITS),
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_tdata_i (s_axis_tdata_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_tdata_o  (m_axis_tdata_o),
    .m_tuser_o  (m_axis_tuser_o),
    .m_tlast_o  (m_axis_tlast_o)
  );

endmodule

### design/meg_datapath.sv
module meg_datapath #(
  parameter int unsigned AXIS_BITS  = meg_pkg::AXIS_BITS_DEF,
  parameter int unsigned COORD_BITS = meg_pkg::COORD_BITS_DEF,
  localparam int unsigned IN_W  = ((2 * COORD_BITS + 2 * AXIS_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((2 * (COORD_BITS + 1) + 7) / 8) * 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [IN_W-1:0]    in_tdata_i,   // center_x, center_y, semi_a, semi_b
  input  meg_pkg::meg_cmd_t  cmd_i,
  output meg_pkg::meg_stat_t stat_o,
  output logic               m_tvalid_o,
  input  logic               m_tready_i,
  output logic [OUT_W-1:0]   m_tdata_o,    // point_x, point_y
  output logic [1:0]         m_tuser_o,    // point_valid, done_res
  output logic               m_tlast_o
);

  localparam int unsigned A     = AXIS_BITS;
  localparam int unsigned C     = COORD_BITS;
  localparam int unsigned CW    = A + 1;
  localparam int unsigned PW    = C + 1;
  localparam int unsigned SW    = (CW > PW) ? CW : PW;
  localparam int unsigned SQW   = 2 * A;
  localparam int unsigned PRW   = 3 * A;
  localparam int unsigned ACC_W = meg_pkg::ACC_W;

  logic signed [C-1:0]   cx_q, cy_q;
  logic [A-1:0]          a_q, b_q;
  logic [SQW-1:0]        a2_q, b2_q;
  logic [PRW-1:0]        ab_q, ba_q;
  logic [CW-1:0]         cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [ACC_W-1:0]      dec_q, dec_d, inc0_q, inc0_d, inc1_q, inc1_d;
  logic [ACC_W-1:0]      p0_q, p0_d, p1_q, p1_d;
  logic [SQW-1:0]        mul_x;
  logic [A-1:0]          mul_y;
  logic [PRW-1:0]        prod;
  logic [ACC_W-1:0]      sa, sb, st0, st1;
  logic [ACC_W-1:0]      ini_p, ini_q, ini_pr, ini_dec, ini_inc0, ini_inc1;
  logic [SW-1:0]         cx_e, cy_e, ox_e, oy_e, xp, xm, yp, ym;
  logic [PW-1:0]         pt_x, pt_y;
  logic                  out_valid_q, out_last_q, out_pv_q, out_done_q;
  logic signed [PW-1:0]  out_x_q, out_y_q;

  // input word capture on a start request
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      cx_q <= in_tdata_i[C-1:0];
      cy_q <= in_tdata_i[2*C-1:C];
      a_q  <= in_tdata_i[2*C+A-1:2*C];
      b_q  <= in_tdata_i[2*C+2*A-1:2*C+A];
    end
  end

  // shared multiplier, one product per cycle
  always_comb begin
    case (cmd_i.mul_sel)
      meg_pkg::MUL_AA:  begin mul_x = SQW'(a_q); mul_y = a_q; end
      meg_pkg::MUL_BB:  begin mul_x = SQW'(b_q); mul_y = b_q; end
      meg_pkg::MUL_A2B: begin mul_x = a2_q;      mul_y = b_q; end
      meg_pkg::MUL_B2A: begin mul_x = b2_q;      mul_y = a_q; end
      default:          begin mul_x = '0;        mul_y = '0;  end
    endcase
  end

  assign prod = PRW'(mul_x) * PRW'(mul_y);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      case (cmd_i.mul_sel)
        meg_pkg::MUL_AA:  a2_q <= prod[SQW-1:0];
        meg_pkg::MUL_BB:  b2_q <= prod[SQW-1:0];
        meg_pkg::MUL_A2B: ab_q <= prod;
        meg_pkg::MUL_B2A: ba_q <= prod;
        default:          ;
      endcase
    end
  end

  // squares and step constants at accumulator width
  assign sa  = ACC_W'(a2_q);
  assign sb  = ACC_W'(b2_q);
  assign st0 = sa << 2;
  assign st1 = sb << 2;

  // region setup terms, roles of the axes swapped for region two
  assign ini_p    = cmd_i.setup_r2 ? sb : sa;
  assign ini_q    = cmd_i.setup_r2 ? sa : sb;
  assign ini_pr   = cmd_i.setup_r2 ? ACC_W'(ba_q) : ACC_W'(ab_q);
  assign ini_dec  = ((ini_q - ini_pr) << 1) + ini_p;
  assign ini_inc0 = (ini_q << 2) + (ini_q << 1);
  assign ini_inc1 = (ini_p << 2) + ini_inc0 - (ini_pr << 2);

  // accumulator next values
  always_comb begin
    cur_x_d = cur_x_q;
    cur_y_d = cur_y_q;
    dec_d   = dec_q;
    inc0_d  = inc0_q;
    inc1_d  = inc1_q;
    p0_d    = p0_q;
    p1_d    = p1_q;
    if (cmd_i.init_r1 || cmd_i.setup_r2) begin
      dec_d  = ini_dec;
      inc0_d = ini_inc0;
      inc1_d = ini_inc1;
      if (cmd_i.setup_r2) begin
        p0_d    = ACC_W'(ba_q);
        p1_d    = '0;
        cur_x_d = CW'(a_q);
        cur_y_d = '0;
      end else begin
        p0_d    = '0;
        p1_d    = ACC_W'(ab_q);
        cur_x_d = '0;
        cur_y_d = CW'(b_q);
      end
    end else if (cmd_i.upd_r1) begin
      cur_x_d = cur_x_q + CW'(1);
      p0_d    = p0_q + sb;
      inc0_d  = inc0_q + st1;
      if (dec_q[ACC_W-1]) begin
        dec_d  = dec_q + inc0_q;
        inc1_d = inc1_q + st1;
      end else begin
        dec_d   = dec_q + inc1_q;
        inc1_d  = inc1_q + st0 + st1;
        cur_y_d = cur_y_q - CW'(1);
        p1_d    = p1_q - sa;
      end
    end else if (cmd_i.upd_r2) begin
      cur_y_d = cur_y_q + CW'(1);
      p1_d    = p1_q + sa;
      inc0_d  = inc0_q + st0;
      if (dec_q[ACC_W-1]) begin
        dec_d  = dec_q + inc0_q;
        inc1_d = inc1_q + st0;
      end else begin
        dec_d   = dec_q + inc1_q;
        inc1_d  = inc1_q + st1 + st0;
        cur_x_d = cur_x_q - CW'(1);
        p0_d    = p0_q - sb;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_x_q <= cur_x_d;
    cur_y_q <= cur_y_d;
    dec_q   <= dec_d;
    inc0_q  <= inc0_d;
    inc1_q  <= inc1_d;
    p0_q    <= p0_d;
    p1_q    <= p1_d;
  end

  // progress comparisons and output-free flag for the controller
  assign stat_o.out_free = !out_valid_q || m_tready_i;
  assign stat_o.p0_lt_p1 = $signed(p0_q) < $signed(p1_q);
  assign stat_o.p1_lt_p0 = $signed(p1_q) < $signed(p0_q);
  assign stat_o.p_eq     = (p0_q == p1_q);

  // symmetric point coordinates around the centre
  assign cx_e = SW'(cx_q);
  assign cy_e = SW'(cy_q);
  assign ox_e = SW'(cur_x_q);
  assign oy_e = SW'(cur_y_q);
  assign xp   = cx_e + ox_e;
  assign xm   = cx_e - ox_e;
  assign yp   = cy_e + oy_e;
  assign ym   = cy_e - oy_e;

  always_comb begin
    case (cmd_i.quad)
      meg_pkg::Q_PP: begin pt_x = xp[PW-1:0]; pt_y = yp[PW-1:0]; end
      meg_pkg::Q_PM: begin pt_x = xp[PW-1:0]; pt_y = ym[PW-1:0]; end
      meg_pkg::Q_MM: begin pt_x = xm[PW-1:0]; pt_y = ym[PW-1:0]; end
      meg_pkg::Q_MP: begin pt_x = xm[PW-1:0]; pt_y = yp[PW-1:0]; end
      default:       begin pt_x = '0;         pt_y = '0;         end
    endcase
  end

  // output register, valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_pt || cmd_i.emit_done) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register, payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_pt) begin
      out_x_q    <= pt_x;
      out_y_q    <= pt_y;
      out_pv_q   <= 1'b1;
      out_last_q <= (cmd_i.quad == meg_pkg::Q_MP);
      out_done_q <= 1'b0;
    end else if (cmd_i.emit_done) begin
      out_x_q    <= '0;
      out_y_q    <= '0;
      out_pv_q   <= 1'b0;
      out_last_q <= 1'b1;
      out_done_q <= 1'b1;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = OUT_W'({out_y_q, out_x_q});
  assign m_tuser_o  = {out_done_q, out_pv_q};
  assign m_tlast_o  = out_last_q;

endmodule

### design/meg_ctrl.sv
`include "midpoint_ellipse_generator_unit_defines.svh"

module meg_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_tvalid_i,
  input  logic               s_tuser_i,   // req_type
  output logic               s_tready_o,
  input  meg_pkg::meg_stat_t stat_i,
  output meg_pkg::meg_cmd_t  cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_INIT = 6'b000100,
    S_EVAL = 6'b001000,
    S_EMIT = 6'b010000,
    S_FIN  = 6'b100000
  } state_e;

  typedef enum logic [5:0] {
    PH_IDLE    = 6'b000001,
    PH_R1_LOOP = 6'b000010,
    PH_R1_TAIL = 6'b000100,
    PH_R2_LOOP = 6'b001000,
    PH_R2_TAIL = 6'b010000,
    PH_DONE    = 6'b100000
  } phase_e;

  state_e     state_q, state_d;
  phase_e     phase_q, phase_d;
  logic [1:0] mul_cnt_q, mul_cnt_d;
  logic [1:0] quad_cnt_q, quad_cnt_d;

  // sequencer
  always_comb begin
    state_d       = state_q;
    phase_d       = phase_q;
    mul_cnt_d     = mul_cnt_q;
    quad_cnt_d    = quad_cnt_q;
    cmd_o         = '0;
    cmd_o.mul_sel = meg_pkg::mul_sel_e'(mul_cnt_q);
    cmd_o.quad    = meg_pkg::quad_e'(quad_cnt_q);
    s_tready_o    = (state_q == S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (s_tvalid_i) begin
          if (s_tuser_i == meg_pkg::REQ_START) begin
            cmd_o.load_in = 1'b1;
            mul_cnt_d     = '0;
            state_d       = S_MUL;
          end else begin
            state_d = S_EVAL;
          end
        end
      end
      S_MUL: begin
        cmd_o.mul_en = 1'b1;
        mul_cnt_d    = mul_cnt_q + 2'd1;
        if (cmd_o.mul_sel == meg_pkg::MUL_B2A) begin
          state_d = S_INIT;
        end
      end
      S_INIT: begin
        cmd_o.init_r1 = 1'b1;
        phase_d       = PH_R1_LOOP;
        state_d       = S_IDLE;
      end
      // walk through phases that give no points until a group or the end
      S_EVAL: begin
        quad_cnt_d = '0;
        case (phase_q)
          PH_R1_LOOP: begin
            if (stat_i.p0_lt_p1) begin
              state_d = S_EMIT;
            end else begin
              phase_d = PH_R1_TAIL;
            end
          end
          PH_R1_TAIL: begin
            if (stat_i.p_eq) begin
              state_d = S_EMIT;
            end else begin
              cmd_o.setup_r2 = 1'b1;
              phase_d        = PH_R2_LOOP;
            end
          end
          PH_R2_LOOP: begin
            if (stat_i.p1_lt_p0) begin
              state_d = S_EMIT;
            end else begin
              phase_d = PH_R2_TAIL;
            end
          end
          PH_R2_TAIL: begin
            if (stat_i.p_eq) begin
              state_d = S_EMIT;
            end else begin
              phase_d = PH_DONE;
            end
          end
          default: begin
            state_d = S_FIN;
          end
        endcase
      end
      // four points while the output is free, then on the last one update the accumulators or advance the phase
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit_pt = 1'b1;
          quad_cnt_d    = quad_cnt_q + 2'd1;
          if (cmd_o.quad == meg_pkg::Q_MP) begin
            state_d = S_IDLE;
            case (phase_q)
              PH_R1_LOOP: cmd_o.upd_r1 = 1'b1;
              PH_R1_TAIL: begin
                cmd_o.setup_r2 = 1'b1;
                phase_d        = PH_R2_LOOP;
              end
              PH_R2_LOOP: cmd_o.upd_r2 = 1'b1;
              PH_R2_TAIL: phase_d = PH_DONE;
              default:    ;
            endcase
          end
        end
      end
      S_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.emit_done = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      phase_q    <= PH_IDLE;
      mul_cnt_q  <= '0;
      quad_cnt_q <= '0;
    end else begin
      state_q    <= state_d;
      phase_q    <= phase_d;
      mul_cnt_q  <= mul_cnt_d;
      quad_cnt_q <= quad_cnt_d;
    end
  end

  // checks
  `MEG_ASSERT_IMPL(a_load_when_free, cmd_o.emit_pt || cmd_o.emit_done, stat_i.out_free, "output register overwritten")
  `MEG_ASSERT_IMPL(a_one_update, 1'b1, $onehot0({cmd_o.init_r1, cmd_o.setup_r2, cmd_o.upd_r1, cmd_o.upd_r2}), "conflicting accumulator updates")
  `MEG_ASSERT_NEXT(a_mul_to_init, state_q == S_MUL && cmd_o.mul_sel == meg_pkg::MUL_B2A, state_q == S_INIT, "product sequence did not end in setup")
  `MEG_ASSERT_NEXT(a_group_ends, cmd_o.emit_pt && cmd_o.quad == meg_pkg::Q_MP, state_q == S_IDLE, "point group did not end after fourth point")

endmodule
